>>> rtl/core/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared constants and types for the YUYV 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

   // Fraction bits of the Q16 coefficients
   localparam int FRAC_W = 16;
   // Signed width of the products and per-pixel sums
   localparam int SUM_W = 27;
   // Width of one colour channel and of a luma sample
   localparam int CHAN_W = 8;
   // Signed width of the truncated red chroma term (range -179..178)
   localparam int RED_Q_W = 10;

   localparam logic signed [SUM_W-1:0] COEF_R_CR = 27'sd91881;
   localparam logic signed [SUM_W-1:0] COEF_G_CB = 27'sd22554;
   localparam logic signed [SUM_W-1:0] COEF_G_CR = 27'sd46802;
   localparam logic signed [SUM_W-1:0] COEF_B_CB = 27'sd116130;

   localparam logic [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << FRAC_W) - 1);
   localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

   // Chroma products shared by both pixels of a pair
   typedef struct packed {
      logic signed [SUM_W-1:0] red_cr;
      logic signed [SUM_W-1:0] green_cb;
      logic signed [SUM_W-1:0] green_cr;
      logic signed [SUM_W-1:0] blue_cb;
   } prod_type;

endpackage

>>> rtl/core/y2r_pixel.sv
// ----------------------------------------------------------------------------
// y2r_pixel
// Two-stage back end for one pixel: forms the channel sums from the shared
// chroma products, then truncates toward zero and saturates to 0..255.
// ----------------------------------------------------------------------------
module y2r_pixel (
   input  logic                            clock,
   input  logic [y2r_pkg::CHAN_W-1:0]      luma,
   input  y2r_pkg::prod_type               prod,
   output logic [y2r_pkg::CHAN_W-1:0]      red,
   output logic [y2r_pkg::CHAN_W-1:0]      green,
   output logic [y2r_pkg::CHAN_W-1:0]      blue
);

   localparam int FW = y2r_pkg::FRAC_W;
   localparam int SW = y2r_pkg::SUM_W;
   localparam int CW = y2r_pkg::CHAN_W;
   localparam int QW = y2r_pkg::RED_Q_W;

   // sum stage
   logic signed [SW-1:0] luma_scaled;
   logic signed [SW-1:0] red_biased;
   logic signed [QW-1:0] red_quot_in, red_quot_ff;
   logic signed [SW-1:0] green_sum_in, green_sum_ff;
   logic signed [SW-1:0] blue_sum_in, blue_sum_ff;
   logic [CW-1:0]        luma_ff;

   // saturation stage
   logic signed [QW:0]   red_sum;
   logic [CW-1:0]        red_in, red_ff;
   logic [CW-1:0]        green_in, green_ff;
   logic [CW-1:0]        blue_in, blue_ff;

   always_comb begin
      luma_scaled  = signed'(SW'({luma, FW'(0)}));
      // bias negative products so the shift truncates toward zero
      red_biased   = prod.red_cr + (prod.red_cr[SW-1] ? signed'(y2r_pkg::FRAC_MASK) : '0);
      red_quot_in  = red_biased[FW+QW-1:FW];
      green_sum_in = luma_scaled - prod.green_cb - prod.green_cr;
      blue_sum_in  = luma_scaled + prod.blue_cb;
   end

   always_ff @(posedge clock) begin
      luma_ff      <= luma;
      red_quot_ff  <= red_quot_in;
      green_sum_ff <= green_sum_in;
      blue_sum_ff  <= blue_sum_in;
   end

   // a negative sum truncates to zero or below, so it clamps to zero directly
   function automatic logic [CW-1:0] sat_q16(input logic signed [SW-1:0] v);
      logic [CW-1:0] res;
      if (v[SW-1]) begin
         res = '0;
      end else if (|v[SW-2:FW+CW]) begin
         res = y2r_pkg::CHAN_MAX;
      end else begin
         res = v[FW+CW-1:FW];
      end
      return res;
   endfunction

   always_comb begin
      red_sum = signed'((QW+1)'({1'b0, luma_ff})) + (QW+1)'(red_quot_ff);
      if (red_sum[QW]) begin
         red_in = '0;
      end else if (|red_sum[QW-1:CW]) begin
         red_in = y2r_pkg::CHAN_MAX;
      end else begin
         red_in = red_sum[CW-1:0];
      end
      green_in = sat_q16(green_sum_ff);
      blue_in  = sat_q16(blue_sum_ff);
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

>>> rtl/core/yuyv_to_rgb24_converter_top.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb24_converter_top
// Converts one packed 4:2:2 group (Y0, Cb, Y1, Cr) into two RGB888 pixels
// with full-range BT.601 equations in Q16 fixed point.
// ----------------------------------------------------------------------------
// rsp_strobe rises together with the result, which passes the input, product,
// sum and saturation register stages in that order.
// Throughput: one request per cycle; busy stays low, the four-stage pipeline
// never stalls and the receiver takes every result as it appears.
// Reset clears the valid pipeline; no result is shown until a new request.
// ----------------------------------------------------------------------------
module yuyv_to_rgb24_converter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [y2r_pkg::CHAN_W-1:0]  req_luma_first,
   input  logic [y2r_pkg::CHAN_W-1:0]  req_chroma_blue,
   input  logic [y2r_pkg::CHAN_W-1:0]  req_luma_second,
   input  logic [y2r_pkg::CHAN_W-1:0]  req_chroma_red,
   input  logic                        req_frame_end,
   output logic                        rsp_strobe,
   output logic [y2r_pkg::CHAN_W-1:0]  rsp_red_first,
   output logic [y2r_pkg::CHAN_W-1:0]  rsp_green_first,
   output logic [y2r_pkg::CHAN_W-1:0]  rsp_blue_first,
   output logic [y2r_pkg::CHAN_W-1:0]  rsp_red_second,
   output logic [y2r_pkg::CHAN_W-1:0]  rsp_green_second,
   output logic [y2r_pkg::CHAN_W-1:0]  rsp_blue_second,
   output logic                        rsp_frame_end_out
);

   localparam int CW = y2r_pkg::CHAN_W;
   localparam int SW = y2r_pkg::SUM_W;
   localparam int STAGES = 4;

   logic                 accept;
   logic [STAGES-1:0]    valid_in, valid_ff;
   logic [STAGES-1:0]    frame_end_in, frame_end_ff;

   // input stage
   logic signed [CW-1:0] cb_diff_in, cb_diff_ff;
   logic signed [CW-1:0] cr_diff_in, cr_diff_ff;
   logic [CW-1:0]        luma0_s1_ff, luma1_s1_ff;

   // product stage
   y2r_pkg::prod_type    prod_in, prod_ff;
   logic [CW-1:0]        luma0_s2_ff, luma1_s2_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // subtracting the offset of 128 from an 8-bit code flips its top bit
   assign cb_diff_in = signed'({~req_chroma_blue[CW-1], req_chroma_blue[CW-2:0]});
   assign cr_diff_in = signed'({~req_chroma_red[CW-1], req_chroma_red[CW-2:0]});

   assign valid_in     = {valid_ff[STAGES-2:0], accept};
   assign frame_end_in = {frame_end_ff[STAGES-2:0], req_frame_end};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_end_ff <= frame_end_in;
      cb_diff_ff   <= cb_diff_in;
      cr_diff_ff   <= cr_diff_in;
      luma0_s1_ff  <= req_luma_first;
      luma1_s1_ff  <= req_luma_second;
   end

   always_comb begin
      prod_in.red_cr   = SW'(y2r_pkg::COEF_R_CR) * SW'(cr_diff_ff);
      prod_in.green_cb = SW'(y2r_pkg::COEF_G_CB) * SW'(cb_diff_ff);
      prod_in.green_cr = SW'(y2r_pkg::COEF_G_CR) * SW'(cr_diff_ff);
      prod_in.blue_cb  = SW'(y2r_pkg::COEF_B_CB) * SW'(cb_diff_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      luma0_s2_ff <= luma0_s1_ff;
      luma1_s2_ff <= luma1_s1_ff;
   end

   y2r_pixel u_pixel_first (
      .clock (clock),
      .luma  (luma0_s2_ff),
      .prod  (prod_ff),
      .red   (rsp_red_first),
      .green (rsp_green_first),
      .blue  (rsp_blue_first)
   );

   y2r_pixel u_pixel_second (
      .clock (clock),
      .luma  (luma1_s2_ff),
      .prod  (prod_ff),
      .red   (rsp_red_second),
      .green (rsp_green_second),
      .blue  (rsp_blue_second)
   );

   assign rsp_strobe        = valid_ff[STAGES-1];
   assign rsp_frame_end_out = frame_end_ff[STAGES-1];

endmodule
